### rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the NFA engine.
// Each macro expands to one labeled concurrent assertion on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, disabled while in reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Property checked at every rising edge, disabled while in reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`endif

### rtl/ncme_pkg.sv
// Package of the NFA closure and move engine: codes and command types.
// No dependencies.
`default_nettype none
package ncme_pkg;
  typedef enum logic [1:0] {
    MODE_LOAD_STATE = 2'd0,
    MODE_LOAD_CLASS = 2'd1,
    MODE_START      = 2'd2,
    MODE_STEP       = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EDGE_LITERAL = 2'd0,
    EDGE_EPSILON = 2'd1,
    EDGE_CLASS   = 2'd2,
    EDGE_NONE    = 2'd3
  } edge_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_state;   // write state table entry from input
    logic load_class;   // write class word from input
    logic capture;      // register the input item
    logic clear_next;   // clear the next set
    logic clear_act;    // clear the active set
    logic seed_start;   // put the start state into the active set
    logic commit_next;  // active set <= next set
    logic scan_rd;      // read table entry of scan index (and class word)
    logic scan_eval;    // evaluate move or push for the entry read last cycle
    logic scan_push;    // scan pushes active members (closure seeding)
    logic scan_inc;     // advance scan index
    logic scan_clr;     // reset scan index to zero
    logic pop_rd;       // pop stack top; its table entry is read next cycle
    logic pop_eval;     // follow epsilon edges of the popped entry
    logic rep_eval;     // update report from entry read last cycle
    logic rep_clr;      // clear report
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;    // scan index is at its last state
    logic stack_empty;  // no pending entries on the stack
    logic follow_busy;  // the second follow of an epsilon entry is pending
  } dp_sts_t;
endpackage
`default_nettype wire

### rtl/ncme_if.sv
// Valid/ready channel interfaces of the NFA closure and move engine.
// Depends on nothing.
`default_nettype none
interface ncme_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  state_index;
  logic [1:0]  edge_kind;
  logic [7:0]  char_value;
  logic [8:0]  next_one;
  logic [8:0]  next_two;
  logic        accept_flag;
  logic [1:0]  anchor_kind;
  logic [1:0]  class_word_index;
  logic [63:0] class_word;
  modport source (output valid, mode, state_index, edge_kind, char_value, next_one,
                  next_two, accept_flag, anchor_kind, class_word_index, class_word,
                  input ready);
  modport sink (input valid, mode, state_index, edge_kind, char_value, next_one,
                next_two, accept_flag, anchor_kind, class_word_index, class_word,
                output ready);
endinterface

interface ncme_out_if;
  logic       valid;
  logic       ready;
  logic       set_empty;
  logic       accepting;
  logic [7:0] accept_state;
  logic [1:0] accept_anchor;
  modport source (output valid, set_empty, accepting, accept_state, accept_anchor,
                  input ready);
  modport sink (input valid, set_empty, accepting, accept_state, accept_anchor,
                output ready);
endinterface
`default_nettype wire

### rtl/nfa_closure_move_engine.sv
// Top level of the NFA closure and move engine.
// Depends on ncme_pkg, ncme_if, ncme_ctrl and ncme_datapath.
//
// Usage: items arrive on in_ch (valid/ready); each item yields one result
// on out_ch. Load items write one state entry or one class word; a start item
// seeds the active set with one state and takes its epsilon closure; a step
// item moves the set on a character and takes the closure.
// One item is in flight at a time; ready is high only while idle, from the
// cycle after the result transfer.
// Phases in order: a step item runs the move scan, then the closure seed scan,
// the closure pops and the report scan; a start item skips the move scan, and a
// load item runs only the report scan after its write. Move and closure seed
// scans read and then evaluate each state, paced by the registered table read;
// the report scan takes one cycle a state; each pop goes through the stack read,
// the table read and the first follow, and an epsilon entry adds a second follow.
// Reset clears the active set and all control state; the state table and
// class maps are undefined until loaded and need no clearing pass.
// When the receiver stalls, the result holds on out_ch and no new item is
// accepted until it is taken.
`default_nettype none
module nfa_closure_move_engine import ncme_pkg::*; #(
  parameter int NUM_STATES = 256
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ncme_in_if.sink    in_ch,
  ncme_out_if.source out_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  ncme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .mode_i      (in_ch.mode),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ncme_datapath #(.NumStates(NUM_STATES)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .state_index_i      (in_ch.state_index),
    .edge_kind_i        (in_ch.edge_kind),
    .char_value_i       (in_ch.char_value),
    .next_one_i         (in_ch.next_one),
    .next_two_i         (in_ch.next_two),
    .accept_flag_i      (in_ch.accept_flag),
    .anchor_kind_i      (in_ch.anchor_kind),
    .class_word_index_i (in_ch.class_word_index),
    .class_word_i       (in_ch.class_word),
    .set_empty_o        (out_ch.set_empty),
    .accepting_o        (out_ch.accepting),
    .accept_state_o     (out_ch.accept_state),
    .accept_anchor_o    (out_ch.accept_anchor)
  );
endmodule
`default_nettype wire

### rtl/ncme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ncme_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/ncme_datapath.sv
// Datapath of the NFA engine: state table, class maps, active and next sets,
// closure stack and report logic. Depends on ncme_pkg and ncme_ram.
`default_nettype none
`include "assert_macros.svh"
module ncme_datapath import ncme_pkg::*; #(
  parameter int NumStates = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  input  wire logic [7:0]  state_index_i,
  input  wire logic [1:0]  edge_kind_i,
  input  wire logic [7:0]  char_value_i,
  input  wire logic [8:0]  next_one_i,
  input  wire logic [8:0]  next_two_i,
  input  wire logic        accept_flag_i,
  input  wire logic [1:0]  anchor_kind_i,
  input  wire logic [1:0]  class_word_index_i,
  input  wire logic [63:0] class_word_i,
  output logic             set_empty_o,
  output logic             accepting_o,
  output logic [7:0]       accept_state_o,
  output logic [1:0]       accept_anchor_o
);
  localparam int IdxW = $clog2(NumStates);
  localparam int CntW = $clog2(NumStates + 1);
  localparam int EntW = 31;

  // Registered character of the item being worked on.
  logic [7:0] chr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      chr_q <= char_value_i;
    end
  end

  // Index bounds check on the 8-bit state index.
  logic            idx_ok;
  logic [IdxW-1:0] in_idx;
  assign idx_ok = (32'(state_index_i) < 32'(NumStates));
  assign in_idx = IdxW'(state_index_i);

  // Read address selection: scan index, or the stack word read last cycle.
  logic [CntW-1:0] scan_q;
  logic [CntW-1:0] sp_q;
  logic            pop_q;
  logic [IdxW-1:0] stk_top;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] rd_idx_q;
  assign rd_idx = pop_q ? stk_top : scan_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_idx_q <= rd_idx;
    end
  end

  // State table.
  logic [EntW-1:0] ent_wdata;
  logic [EntW-1:0] ent;
  assign ent_wdata = {anchor_kind_i, accept_flag_i, next_two_i, next_one_i,
                      char_value_i, edge_kind_i};

  ncme_ram #(.Width(EntW), .Depth(NumStates)) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_state && idx_ok),
    .waddr_i (in_idx),
    .wdata_i (ent_wdata),
    .raddr_i (rd_idx),
    .rdata_o (ent)
  );

  // Class maps: four 64-bit words per state.
  logic [63:0] cls_word;
  ncme_ram #(.Width(64), .Depth(4 * NumStates)) u_class (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_class && idx_ok),
    .waddr_i ({in_idx, class_word_index_i}),
    .wdata_i (class_word_i),
    .raddr_i ({rd_idx, chr_q[7:6]}),
    .rdata_o (cls_word)
  );

  // Closure stack. The top word is read at the pop and used in the following cycle.
  logic [IdxW-1:0] push_val;
  logic            push_en;
  ncme_ram #(.Width(IdxW), .Depth(NumStates)) u_stack (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (sp_q[IdxW-1:0]),
    .wdata_i (push_val),
    .raddr_i (sp_q[IdxW-1:0] - IdxW'(1)),
    .rdata_o (stk_top)
  );

  // Entry fields.
  edge_e           e_kind;
  logic [7:0]      e_chr;
  logic [8:0]      e_n1;
  logic [8:0]      e_n2;
  logic            e_acc;
  logic [1:0]      e_anc;
  assign e_kind = edge_e'(ent[1:0]);
  assign e_chr  = ent[9:2];
  assign e_n1   = ent[18:10];
  assign e_n2   = ent[27:19];
  assign e_acc  = ent[28];
  assign e_anc  = ent[30:29];

  function automatic logic succ_ok(input logic [8:0] s);
    succ_ok = (s != 9'd256) && (32'(s) < 32'(NumStates));
  endfunction

  // Active and next sets.
  logic [NumStates-1:0] act_q;
  logic [NumStates-1:0] nxt_q;
  logic [NumStates-1:0] nxt_d;
  logic [NumStates-1:0] seed_vec;
  logic                 hit;
  assign hit = ((e_kind == EDGE_LITERAL) && (e_chr == chr_q)) ||
               ((e_kind == EDGE_CLASS) && cls_word[chr_q[5:0]]);

  always_comb begin
    seed_vec = '0;
    if (idx_ok) begin
      seed_vec[in_idx] = 1'b1;
    end
  end

  // Epsilon follow: the second successor is handled in the cycle after.
  logic            fol2_q;
  logic [8:0]      n2_q;
  logic [8:0]      fol_s;
  logic [IdxW-1:0] fol_idx;
  logic            fol_en;
  logic            is_mem;
  logic            sp_room;

  always_comb begin
    fol_s  = 9'd256;
    fol_en = 1'b0;
    if (cmd_i.pop_eval && !fol2_q) begin
      fol_s  = e_n1;
      fol_en = (e_kind == EDGE_EPSILON);
    end else if (fol2_q) begin
      fol_s  = n2_q;
      fol_en = 1'b1;
    end
  end

  assign fol_idx = IdxW'(fol_s);
  assign is_mem  = act_q[fol_idx];
  assign sp_room = (sp_q < CntW'(NumStates));

  logic scan_member;
  assign scan_member = act_q[rd_idx_q];

  always_comb begin
    nxt_d = nxt_q;
    if (cmd_i.clear_next) begin
      nxt_d = '0;
    end else if (cmd_i.scan_eval && !cmd_i.scan_push && scan_member && hit &&
                 succ_ok(e_n1)) begin
      nxt_d[IdxW'(e_n1)] = 1'b1;
    end
  end

  always_comb begin
    push_en  = 1'b0;
    push_val = rd_idx_q;
    if (cmd_i.scan_eval && cmd_i.scan_push) begin
      push_en  = scan_member && sp_room;
      push_val = rd_idx_q;
    end else if (fol_en) begin
      push_en  = succ_ok(fol_s) && !is_mem && sp_room;
      push_val = fol_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      nxt_q  <= '0;
      sp_q   <= '0;
      scan_q <= '0;
      pop_q  <= 1'b0;
      fol2_q <= 1'b0;
      n2_q   <= '0;
    end else begin
      nxt_q <= nxt_d;
      if (cmd_i.clear_act) begin
        act_q <= '0;
      end else if (cmd_i.seed_start) begin
        act_q <= seed_vec;
      end else if (cmd_i.commit_next) begin
        act_q <= nxt_d;
      end else if (fol_en && push_en) begin
        act_q[fol_idx] <= 1'b1;
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + CntW'(1);
      end
      // Pop and push never coincide: pop is in its own cycle.
      if (cmd_i.pop_rd) begin
        sp_q <= sp_q - CntW'(1);
      end else if (push_en) begin
        sp_q <= sp_q + CntW'(1);
      end
      pop_q  <= cmd_i.pop_rd;
      fol2_q <= cmd_i.pop_eval && !fol2_q && (e_kind == EDGE_EPSILON);
      if (cmd_i.pop_eval && !fol2_q) begin
        n2_q <= e_n2;
      end
    end
  end

  // Report: first accepting active state in scan order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_empty_o     <= 1'b1;
      accepting_o     <= 1'b0;
      accept_state_o  <= '0;
      accept_anchor_o <= '0;
    end else if (cmd_i.rep_clr) begin
      set_empty_o     <= 1'b1;
      accepting_o     <= 1'b0;
      accept_state_o  <= '0;
      accept_anchor_o <= '0;
    end else if (cmd_i.rep_eval && scan_member) begin
      set_empty_o <= 1'b0;
      if (!accepting_o && e_acc) begin
        accepting_o     <= 1'b1;
        accept_state_o  <= 8'(rd_idx_q);
        accept_anchor_o <= e_anc;
      end
    end
  end

  assign sts_o.scan_last   = (scan_q == CntW'(NumStates - 1));
  assign sts_o.stack_empty = (sp_q == '0) && !push_en;
  assign sts_o.follow_busy = fol2_q || (cmd_i.pop_eval && (e_kind == EDGE_EPSILON));

  `ASSERT_ALWAYS(a_sp_bound, sp_q <= CntW'(NumStates))
  `ASSERT_IMPL(a_pop_nonempty, cmd_i.pop_rd, sp_q != '0)
  `ASSERT_IMPL(a_push_sets_member, fol_en && push_en, ##1 act_q[$past(fol_idx)])
endmodule
`default_nettype wire

### rtl/ncme_ctrl.sv
// Controller state machine of the NFA engine: sequences load, move scan,
// closure and report phases. Depends on ncme_pkg.
`default_nettype none
`include "assert_macros.svh"
module ncme_ctrl import ncme_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output dp_cmd_t         cmd_o,
  input  wire dp_sts_t    sts_i
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MRD    = 10'b0000000010,  // move scan: read entry
    S_MEV    = 10'b0000000100,  // move scan: evaluate
    S_CRD    = 10'b0000001000,  // closure seed scan: read
    S_CEV    = 10'b0000010000,  // closure seed scan: evaluate
    S_POP    = 10'b0000100000,  // pop stack
    S_PRD    = 10'b0001000000,  // read table entry of the popped state
    S_FOL    = 10'b0010000000,  // follow epsilon successors
    S_RRD    = 10'b0100000000,  // report scan: read / evaluate
    S_OUT    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   rep_ev_q, rep_ev_d;
  logic   rep_end_q, rep_end_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rep_ev_q  <= 1'b0;
      rep_end_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rep_ev_q  <= rep_ev_d;
      rep_end_q <= rep_end_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    rep_ev_d  = 1'b0;
    rep_end_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture  = 1'b1;
          cmd_o.scan_clr = 1'b1;
          cmd_o.rep_clr  = 1'b1;
          unique case (mode_e'(mode_i))
            MODE_LOAD_STATE: begin
              cmd_o.load_state = 1'b1;
              state_d = S_RRD;
            end
            MODE_LOAD_CLASS: begin
              cmd_o.load_class = 1'b1;
              state_d = S_RRD;
            end
            MODE_START: begin
              cmd_o.seed_start = 1'b1;
              state_d = S_CRD;
            end
            MODE_STEP: begin
              cmd_o.clear_next = 1'b1;
              state_d = S_MRD;
            end
          endcase
        end
      end
      S_MRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_MEV;
      end
      S_MEV: begin
        cmd_o.scan_eval = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.scan_clr    = 1'b1;
          cmd_o.commit_next = 1'b1;
          state_d = S_CRD;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d = S_MRD;
        end
      end
      S_CRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_CEV;
      end
      S_CEV: begin
        cmd_o.scan_eval = 1'b1;
        cmd_o.scan_push = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_POP;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d = S_CRD;
        end
      end
      S_POP: begin
        if (sts_i.stack_empty) begin
          state_d = S_RRD;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        state_d = S_FOL;
      end
      S_FOL: begin
        if (rep_ev_q) begin
          // Second successor of the entry popped earlier.
          state_d = S_POP;
        end else begin
          cmd_o.pop_eval = 1'b1;
          rep_ev_d = sts_i.follow_busy;
          state_d  = sts_i.follow_busy ? S_FOL : S_POP;
        end
      end
      S_RRD: begin
        cmd_o.rep_eval = rep_ev_q;
        if (rep_end_q) begin
          // The last state was read in the previous cycle and is evaluated now.
          state_d = S_OUT;
        end else begin
          cmd_o.scan_rd = 1'b1;
          rep_ev_d      = 1'b1;
          if (sts_i.scan_last) begin
            rep_end_d = 1'b1;
          end else begin
            cmd_o.scan_inc = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `ASSERT_ALWAYS(a_onehot, $onehot(state_q))
  `ASSERT_IMPL(a_out_hold, out_valid_o && !out_ready_i, ##1 out_valid_o)
endmodule
`default_nettype wire
